/* src/ajaa_pkg.sv */
// Package for the two-link arm joint angle block.
// Holds widths, the item structs, the CORDIC angle table and pipeline constants.
// No dependencies.
package ajaa_pkg;

  localparam int COORD_BITS   = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 32;

  // Forearm vector is formed one bit wider than the coordinates.
  localparam int DIFF_BITS = COORD_BITS + 1;
  // After the quadrant fold a coordinate may need one more bit still.
  localparam int MAG_BITS  = COORD_BITS + 2;
  localparam int LEN_BITS  = $clog2(MAG_BITS);
  // The larger magnitude is normalized so its top bit sits at NORM_TOP - 1.
  localparam int NORM_TOP  = 41;
  localparam int SH_BITS   = $clog2(NORM_TOP + 1);
  // Room for the CORDIC gain above the normalized magnitude, plus sign.
  localparam int XY_BITS   = NORM_TOP + 3;

  // Angle accumulator counts 2^32 units per turn and wraps.
  localparam int Z_BITS = 32;
  localparam logic [Z_BITS-1:0] Z_POS_QTR = 32'h4000_0000;
  localparam logic [Z_BITS-1:0] Z_NEG_QTR = 32'hC000_0000;
  localparam logic [Z_BITS-1:0] Z_ROUND   = (32'd1 << (Z_BITS - ANGLE_BITS)) >> 1;

  // Registers in one CORDIC unit: fold, length, shift, iterations, rounding.
  localparam int CORDIC_LAT = CORDIC_STEPS + 4;

  localparam logic [Z_BITS-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] elbow_x;
    logic signed [COORD_BITS-1:0] elbow_y;
    logic signed [COORD_BITS-1:0] hand_x;
    logic signed [COORD_BITS-1:0] hand_y;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] shoulder_angle;
    logic signed [ANGLE_BITS-1:0] forearm_angle;
  } out_t;

endpackage

/* src/arm_joint_angles_atan2_top.sv */
// Two-link arm joint angles: shoulder and forearm atan2 by two CORDIC pipelines.
// Throughput: one item per cycle unless held by out_stall. Registers from acceptance to out_valid:
// the input register, fold, length, shift, 32 iteration stages and rounding.
// The whole pipeline holds while a finished item waits on out_stall.
// Synchronous active-low reset clears the valid bits only; no other state.
module arm_joint_angles_atan2_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ajaa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ajaa_pkg::out_t out_data
);
  import ajaa_pkg::*;

  logic                         en;
  in_t                          in_r;
  logic [CORDIC_LAT:0]          vld_r;
  logic [CORDIC_LAT:0]          vld_nxt;
  logic signed [DIFF_BITS-1:0]  sh_x, sh_y, fa_x, fa_y;
  logic signed [ANGLE_BITS-1:0] shoulder_angle, forearm_angle;

  assign en       = !(vld_r[CORDIC_LAT] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[CORDIC_LAT-1:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
    end
  end

  assign sh_x = DIFF_BITS'(in_r.elbow_x);
  assign sh_y = DIFF_BITS'(in_r.elbow_y);
  assign fa_x = DIFF_BITS'(in_r.hand_x) - DIFF_BITS'(in_r.elbow_x);
  assign fa_y = DIFF_BITS'(in_r.hand_y) - DIFF_BITS'(in_r.elbow_y);

  ajaa_cordic u_shoulder (
    .clk     (clk),
    .en      (en),
    .x_i     (sh_x),
    .y_i     (sh_y),
    .angle_o (shoulder_angle)
  );

  ajaa_cordic u_forearm (
    .clk     (clk),
    .en      (en),
    .x_i     (fa_x),
    .y_i     (fa_y),
    .angle_o (forearm_angle)
  );

  assign out_valid               = vld_r[CORDIC_LAT];
  assign out_data.shoulder_angle = shoulder_angle;
  assign out_data.forearm_angle  = forearm_angle;

endmodule

/* src/ajaa_cordic.sv */
// Pipelined CORDIC vectoring unit: atan2 of one vector per cycle while en is high.
// Quadrant fold, normalization, one iteration per stage, then rounding.
// Depends on ajaa_pkg.
module ajaa_cordic (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [ajaa_pkg::DIFF_BITS-1:0] x_i,
  input  logic signed [ajaa_pkg::DIFF_BITS-1:0] y_i,
  output logic signed [ajaa_pkg::ANGLE_BITS-1:0] angle_o
);
  import ajaa_pkg::*;

  // Fold stage.
  logic signed [MAG_BITS-1:0] xe, ye;
  logic signed [MAG_BITS-1:0] fx_nxt, fy_nxt;
  logic [Z_BITS-1:0]          zf_nxt;
  logic signed [MAG_BITS-1:0] fx_r, fy_r;
  logic [Z_BITS-1:0]          zf_r;
  logic                       zero_f_r;

  always_comb begin
    xe = MAG_BITS'(x_i);
    ye = MAG_BITS'(y_i);
    fx_nxt = xe;
    fy_nxt = ye;
    zf_nxt = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        fx_nxt = ye;
        fy_nxt = -xe;
        zf_nxt = Z_POS_QTR;
      end else begin
        fx_nxt = -ye;
        fy_nxt = xe;
        zf_nxt = Z_NEG_QTR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r     <= fx_nxt;
      fy_r     <= fy_nxt;
      zf_r     <= zf_nxt;
      zero_f_r <= (x_i == '0) && (y_i == '0);
    end
  end

  // Length stage: bit length of the larger magnitude gives the shift.
  logic signed [MAG_BITS-1:0] fy_abs;
  logic [MAG_BITS-2:0]        mag;
  logic [LEN_BITS-1:0]        len;
  logic [SH_BITS-1:0]         sh_nxt;
  logic signed [MAG_BITS-1:0] fx1_r, fy1_r;
  logic [SH_BITS-1:0]         sh1_r;
  logic [Z_BITS-1:0]          z1_r;
  logic                       zero1_r;

  always_comb begin
    fy_abs = fy_r[MAG_BITS-1] ? -fy_r : fy_r;
    mag    = fx_r[MAG_BITS-2:0] | fy_abs[MAG_BITS-2:0];
    len    = '0;
    for (int b = 0; b < MAG_BITS - 1; b++) begin
      if (mag[b]) begin
        len = LEN_BITS'(b + 1);
      end
    end
    sh_nxt = SH_BITS'(NORM_TOP - int'(len));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx1_r   <= fx_r;
      fy1_r   <= fy_r;
      sh1_r   <= sh_nxt;
      z1_r    <= zf_r;
      zero1_r <= zero_f_r;
    end
  end

  // Shift stage feeds the first iteration.
  logic signed [XY_BITS-1:0] x_r [CORDIC_STEPS+1];
  logic signed [XY_BITS-1:0] y_r [CORDIC_STEPS+1];
  logic [Z_BITS-1:0]         z_r [CORDIC_STEPS+1];
  logic                      zero_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= XY_BITS'(fx1_r) <<< sh1_r;
      y_r[0]    <= XY_BITS'(fy1_r) <<< sh1_r;
      z_r[0]    <= z1_r;
      zero_r[0] <= zero1_r;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic signed [XY_BITS-1:0] xsh, ysh;

    assign xsh = x_r[k] >>> k;
    assign ysh = y_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[k][XY_BITS-1]) begin
          x_r[k+1] <= x_r[k] + ysh;
          y_r[k+1] <= y_r[k] - xsh;
          z_r[k+1] <= z_r[k] + ATAN_TBL[k];
        end else begin
          x_r[k+1] <= x_r[k] - ysh;
          y_r[k+1] <= y_r[k] + xsh;
          z_r[k+1] <= z_r[k] - ATAN_TBL[k];
        end
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  // Rounding stage: keep the top bits of the turn count, round half up.
  logic [Z_BITS-1:0]            z_rnd;
  logic signed [ANGLE_BITS-1:0] angle_nxt;
  logic signed [ANGLE_BITS-1:0] angle_r;

  always_comb begin
    z_rnd     = z_r[CORDIC_STEPS] + Z_ROUND;
    angle_nxt = zero_r[CORDIC_STEPS] ? '0 : z_rnd[Z_BITS-1 -: ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule

/* src/ajaa_checker.sv */
// Port-level checks for the arm joint angle block, bound to its top level.
// Depends on ajaa_pkg and arm_joint_angles_atan2_top.
module ajaa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input ajaa_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input ajaa_pkg::out_t out_data
);
  import ajaa_pkg::*;

  // The input side only holds back when a finished item is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a waiting output item");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind arm_joint_angles_atan2_top ajaa_checker u_ajaa_checker (.*);
